>>> hdl/aavr_pkg.sv
package aavr_pkg;

    localparam int CordicSteps = 16;
    localparam int QueueDepth  = 4;

    // cordic datapath in q30, angle in q16
    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam logic signed [20:0] PiQ16      = 21'sd205887;
    localparam logic signed [20:0] HalfPiQ16  = 21'sd102944;

    localparam logic signed [20:0] AtanQ16 [CordicSteps] = '{
        21'sd51472, 21'sd30386, 21'sd16055, 21'sd8150,
        21'sd4091,  21'sd2047,  21'sd1024,  21'sd512,
        21'sd256,   21'sd128,   21'sd64,    21'sd32,
        21'sd16,    21'sd8,     21'sd4,     21'sd2
    };

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] view_x;
        logic signed [31:0] view_y;
        logic signed [31:0] view_z;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [15:0] turn_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_view_x;
        logic signed [31:0] new_view_y;
        logic signed [31:0] new_view_z;
    } t_out_item;

    // one queue entry: everything the matrix side needs
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [32:0] d_x;
        logic signed [32:0] d_y;
        logic signed [32:0] d_z;
        logic signed [15:0] u_x;
        logic signed [15:0] u_y;
        logic signed [15:0] u_z;
        logic signed [17:0] c;
        logic signed [17:0] s;
        logic signed [17:0] t;
    } t_work;

endpackage

>>> hdl/aavr_front.sv
module aavr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  aavr_pkg::t_in_item i_in_data,
    output logic              o_in_stall,
    output logic              o_push,
    output aavr_pkg::t_work   o_push_data,
    input  logic              i_full
);
    import aavr_pkg::*;

    localparam int Last = CordicSteps;

    logic [Last:0]      r_v;
    logic signed [33:0] r_x    [0:Last];
    logic signed [33:0] r_y    [0:Last];
    logic signed [20:0] r_z    [0:Last];
    logic               r_flip [0:Last];
    t_in_item           r_it   [0:Last];

    logic               en;
    logic signed [20:0] z_raw;
    logic signed [20:0] n_z0;
    logic               n_flip0;
    logic signed [33:0] x_f;
    logic signed [33:0] y_f;
    logic signed [17:0] c14;
    logic signed [17:0] s14;

    assign en         = !r_v[Last] || !i_full;
    assign o_in_stall = !en;
    assign o_push     = r_v[Last] && !i_full;

    // angle q3.13 -> q16, fold into +-pi/2
    always_comb begin
        z_raw   = {{2{i_in_data.turn_angle[15]}}, i_in_data.turn_angle, 3'b000};
        n_z0    = z_raw;
        n_flip0 = 1'b0;
        if (z_raw > HalfPiQ16) begin
            n_z0    = z_raw - PiQ16;
            n_flip0 = 1'b1;
        end else if (z_raw < -HalfPiQ16) begin
            n_z0    = z_raw + PiQ16;
            n_flip0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[Last-1:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it[0]   <= i_in_data;
            r_z[0]    <= n_z0;
            r_flip[0] <= n_flip0;
            r_x[0]    <= CordicGain;
            r_y[0]    <= '0;
        end
    end

    for (genvar k = 0; k < Last; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_z[k] >= 0) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - AtanQ16[k];
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + AtanQ16[k];
                end
                r_flip[k+1] <= r_flip[k];
                r_it[k+1]   <= r_it[k];
            end
        end
    end

    // round to q14 and build the queue entry
    always_comb begin
        x_f = r_flip[Last] ? -r_x[Last] : r_x[Last];
        y_f = r_flip[Last] ? -r_y[Last] : r_y[Last];
        c14 = 18'((x_f + 34'sd32768) >>> 16);
        s14 = 18'((y_f + 34'sd32768) >>> 16);
        o_push_data.pos_x = r_it[Last].pos_x;
        o_push_data.pos_y = r_it[Last].pos_y;
        o_push_data.pos_z = r_it[Last].pos_z;
        o_push_data.d_x   = {r_it[Last].view_x[31], r_it[Last].view_x}
                          - {r_it[Last].pos_x[31], r_it[Last].pos_x};
        o_push_data.d_y   = {r_it[Last].view_y[31], r_it[Last].view_y}
                          - {r_it[Last].pos_y[31], r_it[Last].pos_y};
        o_push_data.d_z   = {r_it[Last].view_z[31], r_it[Last].view_z}
                          - {r_it[Last].pos_z[31], r_it[Last].pos_z};
        o_push_data.u_x   = r_it[Last].axis_x;
        o_push_data.u_y   = r_it[Last].axis_y;
        o_push_data.u_z   = r_it[Last].axis_z;
        o_push_data.c     = c14;
        o_push_data.s     = s14;
        o_push_data.t     = 18'sd16384 - c14;
    end

endmodule

>>> hdl/aavr_queue.sv
module aavr_queue #(
    parameter int Depth = aavr_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  aavr_pkg::t_work i_push_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_not_empty,
    output aavr_pkg::t_work o_pop_data
);
    import aavr_pkg::*;

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    t_work           r_mem [0:Depth-1];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full      = (r_cnt == CW'(Depth));
    assign o_not_empty = (r_cnt != '0);
    assign o_pop_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(Depth - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(Depth - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

>>> hdl/aavr_back.sv
module aavr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_not_empty,
    input  aavr_pkg::t_work    i_pop_data,
    output logic               o_pop,
    output logic               o_out_valid,
    output aavr_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);
    import aavr_pkg::*;

    logic [3:0]         r_bv;
    t_work              r_w0;
    t_work              r_w1;
    t_work              r_w2;
    logic signed [33:0] r_tu [3];
    logic signed [33:0] r_su [3];
    logic signed [29:0] r_e  [3][3];
    logic signed [62:0] r_pr [3][3];
    t_out_item          r_out;

    logic               en;
    logic signed [15:0] ui  [3];
    logic signed [15:0] u1  [3];
    logic signed [32:0] d2  [3];
    logic signed [31:0] p3  [3];
    logic signed [47:0] m   [3][3];
    logic signed [47:0] sk  [3];
    logic signed [65:0] sum [3];
    logic signed [42:0] r   [3];
    logic signed [31:0] sat [3];

    assign en          = !r_bv[3] || !i_out_stall;
    assign o_pop       = en && i_not_empty;
    assign o_out_valid = r_bv[3];
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (en) begin
            r_bv <= {r_bv[2:0], i_not_empty};
        end
    end

    always_comb begin
        ui[0] = i_pop_data.u_x;
        ui[1] = i_pop_data.u_y;
        ui[2] = i_pop_data.u_z;
        u1[0] = r_w0.u_x;
        u1[1] = r_w0.u_y;
        u1[2] = r_w0.u_z;
        d2[0] = r_w1.d_x;
        d2[1] = r_w1.d_y;
        d2[2] = r_w1.d_z;
        p3[0] = r_w2.pos_x;
        p3[1] = r_w2.pos_y;
        p3[2] = r_w2.pos_z;
    end

    // (1-c)*u and s*u
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w0 <= i_pop_data;
            for (int i = 0; i < 3; i++) begin
                r_tu[i] <= i_pop_data.t * ui[i];
                r_su[i] <= i_pop_data.s * ui[i];
            end
        end
    end

    // matrix entries in q42, rounded to q24
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sk[i] = 48'(r_su[i]) <<< 14;
            for (int j = 0; j < 3; j++) begin
                m[i][j] = 48'(r_tu[i]) * 48'(u1[j]);
            end
            m[i][i] = m[i][i] + (48'(r_w0.c) <<< 28);
        end
        m[0][1] = m[0][1] - sk[2];
        m[0][2] = m[0][2] + sk[1];
        m[1][0] = m[1][0] + sk[2];
        m[1][2] = m[1][2] - sk[0];
        m[2][0] = m[2][0] - sk[1];
        m[2][1] = m[2][1] + sk[0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w1 <= r_w0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_e[i][j] <= 30'((m[i][j] + 48'sd131072) >>> 18);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w2 <= r_w1;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pr[i][j] <= 63'(r_e[i][j]) * 63'(d2[j]);
                end
            end
        end
    end

    // row sums, round to q16, add position, saturate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum[i] = 66'(r_pr[i][0]) + 66'(r_pr[i][1]) + 66'(r_pr[i][2])
                   + 66'sd8388608;
            r[i]   = 43'(sum[i] >>> 24) + 43'(p3[i]);
            if (r[i] > 43'sd2147483647) begin
                sat[i] = 32'sh7fffffff;
            end else if (r[i] < -43'sd2147483648) begin
                sat[i] = 32'sh80000000;
            end else begin
                sat[i] = r[i][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.new_view_x <= sat[0];
            r_out.new_view_y <= sat[1];
            r_out.new_view_z <= sat[2];
        end
    end

endmodule

>>> hdl/axis_angle_view_rotation_top.sv
// channel | direction | handshake                  | beat
// in      | input     | i_in_valid / o_in_stall    | position, view point, axis, angle
// out     | output    | o_out_valid / i_out_stall  | rotated view point
//
// one beat accepted per cycle while o_in_stall is low; a beat passes the
// cordic front, the queue memory, then the registered matrix back end
// the cordic pipeline (16 steps plus fold stage) sets the front latency
// reset is synchronous, active low, and clears only the valid and queue state
// a stalled valid output holds the back end; the front keeps filling the queue
// and stalls its input only when the queue is full and its last stage is held
module axis_angle_view_rotation_top #(
    parameter int QDepth = aavr_pkg::QueueDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  aavr_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output aavr_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);
    import aavr_pkg::*;

    // front to queue
    logic  push;
    t_work push_data;
    logic  full;
    // queue to back
    logic  pop;
    logic  not_empty;
    t_work pop_data;

    // direction, angle fold and cordic sine/cosine
    aavr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    // short queue decoupling the two halves
    aavr_queue #(
        .Depth (QDepth)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_not_empty (not_empty),
        .o_pop_data  (pop_data)
    );

    // rotation matrix, matrix-vector product, position add, saturation
    aavr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_not_empty (not_empty),
        .i_pop_data  (pop_data),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
